// ===== rtl/core/bist_pkg.sv =====
// Shared codes and controller/datapath interface types for the bounded integer set table.
package bist_pkg;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;

    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_PRESENT   = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_REMOVED   = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_FOUND     = 3'd5;

    localparam int unsigned CAP_RESET = 64;

    // commands from controller to datapath
    typedef struct packed {
        logic load;      // capture request, clear scan index
        logic rd;        // read entry at scan index
        logic adv;       // advance scan index
        logic rd_next;   // read entry one above scan index
        logic wr_shift;  // write read data down to scan index, advance
        logic append;    // write value at end, grow count
        logic dec;       // shrink count
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [1:0] req;
        logic       scan_end;   // scan index has reached count
        logic       hit;        // read data equals request value
        logic       shift_end;  // no entry above scan index
        logic       full;       // count at effective capacity
    } sts_t;

endpackage

// ===== rtl/core/bist_datapath.sv =====
// Datapath of the bounded integer set table: element memory, scan index, count and capacity.
module bist_datapath #(
    parameter int DEPTH = 64,
    parameter int CW    = 7,
    parameter int AW    = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bist_pkg::cmd_t      cmd,
    output bist_pkg::sts_t      sts,
    input  logic [1:0]          req_type,
    input  logic signed [31:0]  value,
    input  logic                capacity_we,
    input  logic [6:0]          capacity_wdata,
    output logic [CW-1:0]       count
);

    localparam int LW = (CW > 7) ? CW : 7;

    logic [31:0]   mem [DEPTH];
    logic [1:0]    req_reg;
    logic [31:0]   value_reg;
    logic [CW-1:0] idx_reg;
    logic [31:0]   rdata_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [6:0]    cap_reg;
    logic [CW-1:0] idx_inc;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          wr_en;

    assign idx_inc = idx_reg + CW'(1);

    always_comb
    begin
        count_next = count_reg;
        if (cmd.append)
            count_next = count_reg + CW'(1);
        else if (cmd.dec)
            count_next = count_reg - CW'(1);
    end

    // control state: count and capacity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cap_reg   <= 7'(bist_pkg::CAP_RESET);
        end
        else
        begin
            count_reg <= count_next;
            if (capacity_we)
                cap_reg <= capacity_wdata;
        end
    end

    // request capture and scan index
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= req_type;
            value_reg <= value;
            idx_reg   <= '0;
        end
        else if (cmd.adv || cmd.wr_shift)
        begin
            idx_reg <= idx_inc;
        end
    end

    assign rd_addr = cmd.rd_next ? idx_inc[AW-1:0] : idx_reg[AW-1:0];
    assign wr_en   = cmd.append || cmd.wr_shift;
    assign wr_addr = cmd.append ? count_reg[AW-1:0] : idx_reg[AW-1:0];
    assign wr_data = cmd.append ? value_reg : rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd || cmd.rd_next)
            rdata_reg <= mem[rd_addr];
    end

    always_comb
    begin
        sts.req       = req_reg;
        sts.scan_end  = (idx_reg >= count_reg);
        sts.hit       = (rdata_reg == value_reg);
        sts.shift_end = ({1'b0, idx_inc} >= {1'b0, count_reg});
        sts.full      = (LW'(count_reg) >= LW'(cap_reg)) || (count_reg >= CW'(DEPTH));
    end

    assign count = count_reg;

endmodule

// ===== rtl/core/bist_controller.sv =====
// Controller of the bounded integer set table: sequences scan, shift and result.
module bist_controller (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    output logic            done,
    output logic [2:0]      status,
    output bist_pkg::cmd_t  cmd,
    input  bist_pkg::sts_t  sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_SH_RD,
        S_SH_WR
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic       done_reg;
    logic       done_next;
    logic [2:0] status_reg;
    logic [2:0] status_next;

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                if (sts.scan_end)
                begin
                    // value not held
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    unique case (sts.req)
                        bist_pkg::REQ_ADD:
                        begin
                            if (sts.full)
                                status_next = bist_pkg::ST_FULL;
                            else
                            begin
                                cmd.append  = 1'b1;
                                status_next = bist_pkg::ST_ADDED;
                            end
                        end
                        default:
                            status_next = bist_pkg::ST_NOT_FOUND;
                    endcase
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (sts.hit)
                begin
                    unique case (sts.req)
                        bist_pkg::REQ_ADD:
                        begin
                            state_next  = S_IDLE;
                            done_next   = 1'b1;
                            status_next = bist_pkg::ST_PRESENT;
                        end
                        bist_pkg::REQ_REMOVE:
                            state_next = S_SH_RD;
                        default:
                        begin
                            state_next  = S_IDLE;
                            done_next   = 1'b1;
                            status_next = bist_pkg::ST_FOUND;
                        end
                    endcase
                end
                else
                begin
                    cmd.adv    = 1'b1;
                    state_next = S_RD;
                end
            end
            S_SH_RD:
            begin
                if (sts.shift_end)
                begin
                    cmd.dec     = 1'b1;
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    status_next = bist_pkg::ST_REMOVED;
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                    state_next  = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                cmd.wr_shift = 1'b1;
                state_next   = S_SH_RD;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            status_reg <= bist_pkg::ST_ADDED;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;

endmodule

// ===== rtl/core/bounded_integer_set_table.sv =====
// Top level of the bounded integer set table: controller, datapath and checks.
//
// Holds up to DEPTH distinct 32-bit values in insertion order and serves one
// request at a time: add, remove or lookup (request code 3 acts as lookup).
// A request transfers at a clock edge with start high and busy low; busy then
// stays high until the result is on status/element_count, marked by done for
// exactly one cycle. The receiver cannot stall: take the result in that cycle.
// The next request may transfer in the same cycle as done. Timing is set by a
// single-port scan of the element memory, which compares held entries in order
// from the first; a remove shifts each later entry down to close the gap.
// Capacity is written through capacity_we/capacity_wdata; the user must do so
// only while idle, as the block itself does not enforce this. A capacity above
// DEPTH acts as DEPTH and lowering it drops nothing.
// The element memory needs no clearing after reset.
module bounded_integer_set_table #(
    parameter int DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         req_type,
    input  logic signed [31:0] value,
    output logic               done,
    output logic [2:0]         status,
    output logic [6:0]         element_count,
    input  logic               capacity_we,
    input  logic [6:0]         capacity_wdata
);

    // count must hold DEPTH itself; address covers entries 0..DEPTH-1
    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    bist_pkg::cmd_t cmd;
    bist_pkg::sts_t sts;
    logic [CW-1:0]  count;

    bist_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .status (status),
        .cmd    (cmd),
        .sts    (sts)
    );

    bist_datapath #(
        .DEPTH (DEPTH),
        .CW    (CW),
        .AW    (AW)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .req_type       (req_type),
        .value          (value),
        .capacity_we    (capacity_we),
        .capacity_wdata (capacity_wdata),
        .count          (count)
    );

    // report the count masked to the port width
    localparam int EW = (CW > 7) ? CW : 7;
    logic [EW-1:0] count_ext;
    assign count_ext     = EW'(count);
    assign element_count = count_ext[6:0];

    // the set never grows past its storage
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CW'(DEPTH))
        else $error("element count exceeds DEPTH");

    // a transferred request makes the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request transferred but block not busy");

    // an add grows the count by exactly one
    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == bist_pkg::ST_ADDED) |-> (count == $past(count) + CW'(1)))
        else $error("added result without count increment");

    // a remove shrinks the count by exactly one
    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == bist_pkg::ST_REMOVED) |-> (count == $past(count) - CW'(1)))
        else $error("removed result without count decrement");

    // a result only appears once the request is finished
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

endmodule
